// ===== src/ddo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry block
// Fixed-point formats, CORDIC table, controller states and datapath commands.
// ----------------------------------------------------------------------------
package ddo_pkg;

	// CORDIC iteration count, capped at the table length
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int NUM_STEPS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int STEP_W       = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

	// datapath widths
	localparam int ANG_W = 36;  // Q.30 angle
	localparam int XY_W  = 34;  // Q.30 cordic vector
	localparam int MUL_W = 33;  // multiplier operand
	localparam int ACC_W = 80;  // product accumulator
	localparam int POS_W = 48;
	localparam int THE_W = 20;

	// word layout
	localparam int IN_DATA_W  = 152;
	localparam int OUT_DATA_W = 184;

	localparam logic [31:0] MPT_RESET = 32'd427828;

	localparam logic signed [19:0] HALF_TURN_Q8 = 20'sd46080;
	localparam logic signed [19:0] FULL_TURN_Q8 = 20'sd92160;
	localparam logic [MUL_W-1:0]   DEG_TO_RAD   = 33'd292818;

	localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [XY_W-1:0]  GAIN_INV    = 34'sd652032874;

	localparam logic signed [22:0] THETA_MAX = 23'sd524287;
	localparam logic signed [22:0] THETA_MIN = -23'sd524288;
	localparam logic signed [51:0] POS_MAX   = 52'sd140737488355327;
	localparam logic signed [51:0] POS_MIN   = -52'sd140737488355328;

	// item kinds
	localparam logic CMD_YAW     = 1'b0;
	localparam logic CMD_ENCODER = 1'b1;

	// truncated Q.30 arctangent of 2^-i
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE, ST_YAW_DIFF, ST_YAW_MUL, ST_YAW_SET, ST_TICKS, ST_DIST_MUL,
		ST_DIST_SET, ST_REDUCE, ST_CORDIC, ST_X_LO, ST_X_HI, ST_X_POS,
		ST_Y_LO, ST_Y_HI, ST_Y_POS, ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_YAW_DIFF, OP_YAW_MUL, OP_YAW_SET, OP_TICKS,
		OP_DIST_MUL, OP_DIST_SET, OP_REDUCE, OP_CORDIC, OP_MUL_LO, OP_MUL_HI,
		OP_POS, OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             axis;  // 0 x / cosine, 1 y / sine
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic ticks_seen;
		logic in_range;  // angle within [-pi, pi]
		logic out_full;  // output word held and not taken this cycle
	} status_t;

endpackage

// ===== src/diff_drive_odometry_imu_heading.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_imu_heading: dead-reckoning odometry with gyro heading
// Yaw words set the heading; encoder words advance x/y and emit a pose.
// ----------------------------------------------------------------------------
// channel   | direction | contents
// s_axis    | in        | yaw sample or encoder pair, kind in tuser
// m_axis    | out       | pose word
// cfg       | in        | metres_per_tick write
//
// Yaw word: difference, multiply and set steps. First encoder word: latches
// the counts only. Later encoder word: distance, whole-turn reduction if needed,
// the 16-step iterative CORDIC and the shared 33x33 multiplier (five products).
// One word at a time; s_axis_tready is high only when idle. A finished pose
// waits in the output register while the next word is taken; the next pose
// stalls until it has gone.
// Reset clears pose, heading, offset and latched counts at once.
// ----------------------------------------------------------------------------
module diff_drive_odometry_imu_heading import ddo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // yaw_degrees, left_count, right_count, stamp_us
	input  logic [0:0]            s_axis_tuser,  // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // pose_stamp_us, pose_x, pose_y, pose_theta
	input  logic                  cfg_wen,
	input  logic [31:0]           cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	ddo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser[0]),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ddo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== src/ddo_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_ctrl: sequencing controller
// Walks each item through yaw or encoder/CORDIC/projection steps.
// ----------------------------------------------------------------------------
module ddo_ctrl import ddo_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_cmd,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(NUM_STEPS - 1));

	// state and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CORDIC) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = (in_cmd == CMD_YAW) ? ST_YAW_DIFF : ST_TICKS;
			end
			ST_YAW_DIFF: state_d = ST_YAW_MUL;
			ST_YAW_MUL:  state_d = ST_YAW_SET;
			ST_YAW_SET:  state_d = ST_IDLE;
			ST_TICKS:    state_d = status.ticks_seen ? ST_DIST_MUL : ST_IDLE;
			ST_DIST_MUL: state_d = ST_DIST_SET;
			ST_DIST_SET: state_d = ST_REDUCE;
			ST_REDUCE: begin
				if (status.in_range) state_d = ST_CORDIC;
			end
			ST_CORDIC: begin
				if (last_step) state_d = ST_X_LO;
			end
			ST_X_LO:  state_d = ST_X_HI;
			ST_X_HI:  state_d = ST_X_POS;
			ST_X_POS: state_d = ST_Y_LO;
			ST_Y_LO:  state_d = ST_Y_HI;
			ST_Y_HI:  state_d = ST_Y_POS;
			ST_Y_POS: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!status.out_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.op   = OP_NONE;
		cmd.axis = 1'b0;
		cmd.step = step_q;
		case (state_q)
			ST_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_YAW_DIFF: cmd.op = OP_YAW_DIFF;
			ST_YAW_MUL:  cmd.op = OP_YAW_MUL;
			ST_YAW_SET:  cmd.op = OP_YAW_SET;
			ST_TICKS:    cmd.op = OP_TICKS;
			ST_DIST_MUL: cmd.op = OP_DIST_MUL;
			ST_DIST_SET: cmd.op = OP_DIST_SET;
			ST_REDUCE:   cmd.op = OP_REDUCE;
			ST_CORDIC:   cmd.op = OP_CORDIC;
			ST_X_LO:     cmd.op = OP_MUL_LO;
			ST_X_HI:     cmd.op = OP_MUL_HI;
			ST_X_POS:    cmd.op = OP_POS;
			ST_Y_LO: begin
				cmd.op   = OP_MUL_LO;
				cmd.axis = 1'b1;
			end
			ST_Y_HI: begin
				cmd.op   = OP_MUL_HI;
				cmd.axis = 1'b1;
			end
			ST_Y_POS: begin
				cmd.op   = OP_POS;
				cmd.axis = 1'b1;
			end
			ST_EMIT: cmd.op = status.out_full ? OP_NONE : OP_EMIT;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== src/ddo_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_dp: odometry datapath
// Pose state, shared multiplier/accumulator, CORDIC rotator, output register.
// ----------------------------------------------------------------------------
module ddo_dp import ddo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic                  cfg_wen,
	input  logic [31:0]           cfg_wdata,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data
);

	// state
	logic [31:0]             mpt_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [THE_W-1:0] heading_q;
	logic signed [17:0]      yaw_zero_q;
	logic                    yaw_seen_q, ticks_seen_q;
	logic [31:0]             prev_l_q, prev_r_q;
	logic                    out_valid_q;

	// working registers
	logic signed [17:0]      yaw_q;
	logic [31:0]             left_q, right_q;
	logic [63:0]             stamp_q;
	logic [POS_W-1:0]        mag_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        acc_q;
	logic signed [ANG_W-1:0] ang_q;
	logic signed [XY_W-1:0]  cx_q, cy_q;
	logic                    flip_q;
	logic [OUT_DATA_W-1:0]   out_q;

	// yaw difference, folded once each way
	logic signed [19:0] yz, d0, d1, d2;
	always_comb begin
		yz = yaw_seen_q ? 20'(yaw_zero_q) : 20'(yaw_q);
		d0 = 20'(yaw_q) - yz;
		d1 = (d0 > HALF_TURN_Q8) ? d0 - FULL_TURN_Q8 : d0;
		d2 = (d1 < -HALF_TURN_Q8) ? d1 + FULL_TURN_Q8 : d1;
	end

	// heading from rounded product, saturated
	logic [ACC_W-1:0]   yaw_rnd;
	logic signed [22:0] yaw_val;
	logic signed [THE_W-1:0] yaw_sat;
	always_comb begin
		yaw_rnd = acc_q + ACC_W'(32768);
		yaw_val = neg_q ? -$signed({1'b0, yaw_rnd[37:16]}) : $signed({1'b0, yaw_rnd[37:16]});
		if (yaw_val > THETA_MAX)      yaw_sat = THE_W'(THETA_MAX);
		else if (yaw_val < THETA_MIN) yaw_sat = THE_W'(THETA_MIN);
		else                          yaw_sat = THE_W'(yaw_val);
	end

	// wrapped tick deltas; magnitude of the sum kept unsigned (up to 2^32)
	logic [31:0]        dl, dr;
	logic signed [32:0] tsum;
	logic [32:0]        tsum_abs;
	always_comb begin
		dl       = left_q - prev_l_q;
		dr       = right_q - prev_r_q;
		tsum     = 33'($signed(dl)) + 33'($signed(dr));
		tsum_abs = tsum[32] ? -tsum : tsum;
	end

	// shared multiplier
	logic signed [XY_W-1:0] trig;
	logic [MUL_W-1:0]       trig_abs;
	logic                   trig_neg;
	logic [MUL_W-1:0]       mul_a, mul_b;
	logic [2*MUL_W-1:0]     prod;
	always_comb begin
		trig     = cmd.axis ? cy_q : cx_q;
		trig_abs = trig[XY_W-1] ? MUL_W'(-trig) : MUL_W'(trig);
		trig_neg = flip_q ^ trig[XY_W-1];
		mul_a    = MUL_W'(mag_q);
		mul_b    = trig_abs;
		case (cmd.op)
			OP_YAW_MUL:  mul_b = DEG_TO_RAD;
			OP_DIST_MUL: mul_b = {1'b0, mpt_q};
			OP_MUL_LO:   mul_a = {1'b0, mag_q[31:0]};
			OP_MUL_HI:   mul_a = MUL_W'(mag_q[POS_W-1:32]);
			default:     mul_a = MUL_W'(mag_q);
		endcase
		prod = mul_a * mul_b;
	end

	// distance, rounded
	logic [ACC_W-1:0] dist_rnd;
	assign dist_rnd = acc_q + ACC_W'(65536);

	// axis step and saturating accumulate
	logic [ACC_W-1:0]        step_rnd;
	logic signed [51:0]      step_s, pos_sum;
	logic signed [POS_W-1:0] pos_cur, pos_new;
	always_comb begin
		step_rnd = acc_q + ACC_W'(32'd536870912);
		step_s   = $signed({2'b00, step_rnd[79:30]});
		pos_cur  = cmd.axis ? pos_y_q : pos_x_q;
		pos_sum  = (neg_q ^ trig_neg) ? 52'(pos_cur) - step_s : 52'(pos_cur) + step_s;
		if (pos_sum > POS_MAX)      pos_new = POS_W'(POS_MAX);
		else if (pos_sum < POS_MIN) pos_new = POS_W'(POS_MIN);
		else                        pos_new = POS_W'(pos_sum);
	end

	// one CORDIC micro-rotation
	logic signed [XY_W-1:0]  shx, shy;
	logic signed [ANG_W-1:0] atan_v;
	always_comb begin
		shx    = cx_q >>> cmd.step;
		shy    = cy_q >>> cmd.step;
		atan_v = ANG_W'(atan_q30(5'(cmd.step)));
	end

	assign status.ticks_seen = ticks_seen_q;
	assign status.in_range   = (ang_q <= PI_Q30) && (ang_q >= -PI_Q30);
	assign status.out_full   = out_valid_q && !out_ready;
	assign out_valid         = out_valid_q;
	assign out_data          = out_q;

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q        <= MPT_RESET;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			heading_q    <= '0;
			yaw_zero_q   <= '0;
			yaw_seen_q   <= 1'b0;
			ticks_seen_q <= 1'b0;
			prev_l_q     <= '0;
			prev_r_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) mpt_q <= cfg_wdata;
			// output word: set on emit, cleared once taken
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_ready)    out_valid_q <= 1'b0;
			case (cmd.op)
				OP_YAW_DIFF: begin
					if (!yaw_seen_q) begin
						yaw_zero_q <= yaw_q;
						yaw_seen_q <= 1'b1;
					end
				end
				OP_YAW_SET: heading_q <= yaw_sat;
				OP_TICKS: begin
					prev_l_q     <= left_q;
					prev_r_q     <= right_q;
					ticks_seen_q <= 1'b1;
				end
				OP_POS: begin
					if (cmd.axis) pos_y_q <= pos_new;
					else          pos_x_q <= pos_new;
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				yaw_q   <= $signed(in_data[17:0]);
				left_q  <= in_data[49:18];
				right_q <= in_data[81:50];
				stamp_q <= in_data[145:82];
			end
			OP_YAW_DIFF: begin
				mag_q <= POS_W'(d2[19] ? -d2 : d2);
				neg_q <= d2[19];
			end
			OP_YAW_MUL, OP_DIST_MUL, OP_MUL_LO: acc_q <= ACC_W'(prod);
			OP_MUL_HI: acc_q <= acc_q + {prod[ACC_W-33:0], 32'd0};
			OP_TICKS: begin
				mag_q <= POS_W'(tsum_abs);
				neg_q <= tsum[32];
			end
			OP_DIST_SET: begin
				mag_q  <= dist_rnd[64:17];
				ang_q  <= {{2{heading_q[THE_W-1]}}, heading_q, 14'd0};
				cx_q   <= GAIN_INV;
				cy_q   <= '0;
				flip_q <= 1'b0;
			end
			OP_REDUCE: begin
				if (ang_q > PI_Q30) begin
					ang_q <= ang_q - TWO_PI_Q30;
				end else if (ang_q < -PI_Q30) begin
					ang_q <= ang_q + TWO_PI_Q30;
				end else if (ang_q > HALF_PI_Q30) begin
					ang_q  <= ang_q - PI_Q30;
					flip_q <= 1'b1;
				end else if (ang_q < -HALF_PI_Q30) begin
					ang_q  <= ang_q + PI_Q30;
					flip_q <= 1'b1;
				end
			end
			OP_CORDIC: begin
				if (!ang_q[ANG_W-1]) begin
					cx_q  <= cx_q - shy;
					cy_q  <= cy_q + shx;
					ang_q <= ang_q - atan_v;
				end else begin
					cx_q  <= cx_q + shy;
					cy_q  <= cy_q - shx;
					ang_q <= ang_q + atan_v;
				end
			end
			OP_EMIT: out_q <= {4'd0, heading_q, pos_y_q, pos_x_q, stamp_q};
			default: ;
		endcase
	end

endmodule
